// ===== src/plk_pkg.sv =====
package plk_pkg;

    localparam int DATA_W = 32;
    localparam int CNT_W  = 7;

    // operation codes carried by the command beat
    localparam logic [1:0] FUNC_INSERT   = 2'd0;
    localparam logic [1:0] FUNC_DELETE   = 2'd1;
    localparam logic [1:0] FUNC_TRAVERSE = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    // per-cycle action broadcast to every cell
    localparam logic [1:0] CELL_HOLD = 2'd0;
    localparam logic [1:0] CELL_INS  = 2'd1;
    localparam logic [1:0] CELL_DEL  = 2'd2;
    localparam logic [1:0] CELL_ROT  = 2'd3;

    typedef struct packed {
        logic [1:0]              func;
        logic [CNT_W-1:0]        position;
        logic signed [DATA_W-1:0] value_in;
    } plk_cmd_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value_out;
        logic [1:0]              status;
        logic [CNT_W-1:0]        entry_count;
        logic                    last;
    } plk_result_t;

    typedef struct packed {
        logic [1:0]              op;
        logic [CNT_W-1:0]        pos;
        logic [CNT_W-1:0]        tail;
        logic signed [DATA_W-1:0] value;
    } plk_ctrl_t;

endpackage

// ===== src/plk_cell.sv =====
module plk_cell
    import plk_pkg::*;
#(
    parameter int INDEX = 0
)
(
    input  logic                     clk,
    input  plk_ctrl_t                ctrl,
    input  logic signed [DATA_W-1:0] prev_data,
    input  logic signed [DATA_W-1:0] next_data,
    output logic signed [DATA_W-1:0] data
);

    localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        case (ctrl.op)
            CELL_INS:
            begin
                if (IDX == ctrl.pos)
                    data_next = ctrl.value;
                else if (IDX > ctrl.pos)
                    data_next = prev_data;
            end
            CELL_DEL:
            begin
                if (IDX >= ctrl.pos)
                    data_next = next_data;
            end
            CELL_ROT:
            begin
                // tail cell wraps around to the head value
                if (IDX == ctrl.tail)
                    data_next = ctrl.value;
                else
                    data_next = next_data;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ===== src/positional_list_store.sv =====
// Ordered list of up to DEPTH signed 32-bit values, held in a row of cells.
// Command channel: cmd (func, position, value_in) is taken on a rising edge
// where start is high and busy is low.
// Result channel: each result beat sits on result for one cycle with done
// high; the receiver has no way to hold it off and must take it.
// Insert, delete, an unused code and every error give one beat in the cycle
// after the command; the whole row shifts on that same edge, so the next
// command can be taken in the very next cycle.
// Traverse gives count beats, one entry per cycle, the first one once the
// traverse flag and then the result register have been loaded, with last
// marking the final one; busy is high while the traverse runs, up to the
// cycle that registers the final beat, so no command is taken meanwhile.
// The row rotates one place per beat and is back in order when it ends.
// Errors (full list, position out of range, traverse of an empty list) give
// one beat with a nonzero status and leave the list unchanged.
// Reset clears the entry count and any traverse in flight; the entry values
// are not cleared and are never read before they are written.
module positional_list_store
    import plk_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  plk_cmd_t    cmd,
    output logic        done,
    output plk_result_t result
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    logic signed [DATA_W-1:0] cell_data [DEPTH];
    logic signed [DATA_W-1:0] prev_w    [DEPTH];
    logic signed [DATA_W-1:0] next_w    [DEPTH];

    plk_ctrl_t ctrl;

    logic [CNT_W-1:0] count_reg, count_next;
    logic             trav_reg, trav_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             done_reg, done_next;
    plk_result_t      result_reg, result_next;

    logic [CNT_W-1:0] tail;
    logic             accept;

    assign tail   = count_reg - CNT_W'(1);
    assign accept = start && !trav_reg;

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        if (g == 0)
        begin : g_head
            assign prev_w[g] = cell_data[g];
        end
        else
        begin : g_body
            assign prev_w[g] = cell_data[g-1];
        end
        if (g == DEPTH - 1)
        begin : g_end
            assign next_w[g] = cell_data[g];
        end
        else
        begin : g_mid
            assign next_w[g] = cell_data[g+1];
        end

        plk_cell #(
            .INDEX (g)
        ) u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .prev_data (prev_w[g]),
            .next_data (next_w[g]),
            .data      (cell_data[g])
        );
    end

    always_comb
    begin
        ctrl.op     = CELL_HOLD;
        ctrl.pos    = cmd.position;
        ctrl.tail   = tail;
        ctrl.value  = cmd.value_in;
        count_next  = count_reg;
        trav_next   = trav_reg;
        idx_next    = idx_reg;
        done_next   = 1'b0;
        result_next = result_reg;

        if (trav_reg)
        begin
            // emit the head and rotate the row by one place
            ctrl.op                 = CELL_ROT;
            ctrl.value              = cell_data[0];
            done_next               = 1'b1;
            result_next.value_out   = cell_data[0];
            result_next.status      = ST_OK;
            result_next.entry_count = count_reg;
            result_next.last        = (idx_reg == tail);
            idx_next                = idx_reg + CNT_W'(1);
            if (idx_reg == tail)
                trav_next = 1'b0;
        end
        else if (accept)
        begin
            done_next               = 1'b1;
            result_next.value_out   = '0;
            result_next.status      = ST_OK;
            result_next.last        = 1'b1;
            case (cmd.func)
                FUNC_INSERT:
                begin
                    if (count_reg >= DEPTH_C)
                        result_next.status = ST_FULL;
                    else if (cmd.position > count_reg)
                        result_next.status = ST_RANGE;
                    else
                    begin
                        ctrl.op    = CELL_INS;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                FUNC_DELETE:
                begin
                    if (cmd.position >= count_reg)
                        result_next.status = ST_RANGE;
                    else
                    begin
                        ctrl.op               = CELL_DEL;
                        result_next.value_out = cell_data[cmd.position[IDX_W-1:0]];
                        count_next            = count_reg - CNT_W'(1);
                    end
                end
                FUNC_TRAVERSE:
                begin
                    if (count_reg == '0)
                        result_next.status = ST_EMPTY;
                    else
                    begin
                        // set the traverse flag; the traverse branch then produces the beats
                        done_next = 1'b0;
                        trav_next = 1'b1;
                        idx_next  = '0;
                    end
                end
                default:
                begin
                    result_next.status = ST_OK;
                end
            endcase
            result_next.entry_count = count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            trav_reg  <= 1'b0;
            idx_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            trav_reg  <= trav_next;
            idx_reg   <= idx_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign busy   = trav_reg;
    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTH
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("entry count above depth");

    a_trav_holds_count: assert property (@(posedge clk) disable iff (!rst_n)
        trav_reg |=> $stable(count_reg))
        else $error("entry count moved during traverse");

    a_trav_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        trav_reg |-> count_reg != '0)
        else $error("traverse running on an empty list");

    a_trav_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (trav_reg && idx_reg == tail) |=> (!trav_reg && done_reg && result_reg.last))
        else $error("traverse did not end on its final beat");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && result_reg.status != ST_OK) |-> result_reg.value_out == '0)
        else $error("error beat carries a value");
`endif

endmodule
